FILE: hw/rtl/pgm_occ_pkg.sv
// ----------------------------------------------------------------------------
// pgm_occ_pkg
// Shared types and constants of the PGM (P5) to occupancy grid decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pgm_occ_pkg;

  // grid limits and number parsing
  localparam logic [49:0] MaxCells    = 50'd16777216;
  localparam logic [24:0] AccSat      = 25'h1FF_FFFF;
  localparam logic [24:0] AccSatDiv10 = AccSat / 25'd10;
  localparam logic [24:0] MaxvalLimit = 25'd255;

  // result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // configuration register indexes
  localparam logic [1:0] CFG_NEGATE   = 2'd0;
  localparam logic [1:0] CFG_OCC_THR  = 2'd1;
  localparam logic [1:0] CFG_FREE_THR = 2'd2;

  localparam logic [16:0] OccThrReset  = 17'd42598;
  localparam logic [16:0] FreeThrReset = 17'd12845;

  // result kinds
  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_P5      = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE    = 3'd2;
  localparam logic [2:0] ST_BAD_MAXVAL  = 3'd3;
  localparam logic [2:0] ST_TRUNCATED   = 3'd4;
  localparam logic [2:0] ST_MALFORMED   = 3'd5;

  // cell classes
  localparam logic signed [7:0] CELL_OCCUPIED = 8'sd100;
  localparam logic signed [7:0] CELL_FREE     = 8'sd0;
  localparam logic signed [7:0] CELL_UNKNOWN  = -8'sd1;

  // characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_PIX,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    MM_NONE,
    MM_P,
    MM_P5,
    MM_BAD
  } magic_e;

  typedef struct packed {
    logic              negate;
    logic [16:0]       occ_thr;
    logic [16:0]       free_thr;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [23:0]       cell_index;
    logic signed [7:0] cell_value;
    logic [24:0]       image_width;
    logic [24:0]       image_height;
    logic [2:0]        status;
    logic              last_result;
  } result_t;

  function automatic result_t status_result(logic [2:0] st);
    result_t r;
    r             = '0;
    r.kind        = KIND_STATUS;
    r.status      = st;
    r.last_result = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pgm_occ_core.sv
// ----------------------------------------------------------------------------
// pgm_occ_core
// Header tokenizer, size checks and pixel classifier; one byte per cycle while
// fire_i is set, up to two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pgm_occ_core
  import pgm_occ_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cfg_t           cfg_i,
  input  wire logic           fire_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           eof_i,
  output logic [1:0]          push_n_o,
  output result_t [1:0]       push_data_o
);

  phase_e       phase_q, phase_d;
  magic_e       magic_q, magic_d;
  logic [1:0]   tok_cnt_q, tok_cnt_d;
  logic         in_comment_q, in_comment_d;
  logic         in_token_q, in_token_d;
  logic [24:0]  accum_q, accum_d;
  logic         neg_q, neg_d;
  logic         digit_q, digit_d;
  logic         stop_q, stop_d;
  logic [24:0]  width_q, width_d;
  logic [24:0]  height_q, height_d;
  logic [23:0]  col_q, col_d;
  logic [23:0]  row_base_q, row_base_d;
  logic [24:0]  cells_left_q, cells_left_d;

  logic         is_ws, is_digit, skip_sign, do_finish;
  logic [24:0]  acc_base, tok_val;
  logic [28:0]  acc_x10;
  logic         acc_sat;
  logic [49:0]  cells;
  logic [23:0]  col_inc;
  logic [7:0]   num;
  logic [24:0]  scaled, occ_lim, free_lim;
  logic signed [7:0] cls;
  logic         main_en, fail_en;
  result_t      main_r;
  logic [2:0]   fail_st;

  assign is_ws    = (byte_i == CH_SPACE) || (byte_i >= CH_TAB && byte_i <= CH_CR);
  assign is_digit = (byte_i >= CH_0) && (byte_i <= CH_9);

  // a new token starts its number from zero
  assign acc_base = in_token_q ? accum_q : '0;
  assign acc_x10  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                  + {25'd0, byte_i[3:0]};
  assign acc_sat  = (acc_base > AccSatDiv10) || (acc_x10 > {4'd0, AccSat});

  // width and height are settled before the maxval token can end
  assign cells = width_q * height_q;

  // exact compare of num/255 against thr/65536
  assign num      = cfg_i.negate ? byte_i : (8'd255 - byte_i);
  assign scaled   = {1'b0, num, 16'h0000};
  assign occ_lim  = {cfg_i.occ_thr, 8'h00} - {8'h00, cfg_i.occ_thr};
  assign free_lim = {cfg_i.free_thr, 8'h00} - {8'h00, cfg_i.free_thr};
  assign cls      = (scaled > occ_lim)  ? CELL_OCCUPIED :
                    (scaled < free_lim) ? CELL_FREE : CELL_UNKNOWN;

  always_comb begin
    phase_d      = phase_q;
    magic_d      = magic_q;
    tok_cnt_d    = tok_cnt_q;
    in_comment_d = in_comment_q;
    in_token_d   = in_token_q;
    accum_d      = accum_q;
    neg_d        = neg_q;
    digit_d      = digit_q;
    stop_d       = stop_q;
    width_d      = width_q;
    height_d     = height_q;
    col_d        = col_q;
    row_base_d   = row_base_q;
    cells_left_d = cells_left_q;
    skip_sign    = 1'b0;
    do_finish    = 1'b0;
    tok_val      = '0;
    col_inc      = '0;
    main_en      = 1'b0;
    main_r       = '0;
    fail_en      = 1'b0;
    fail_st      = ST_OK;

    if (fire_i) begin
      case (phase_q)
        PH_HDR: begin
          if (in_comment_q) begin
            if (byte_i == CH_LF) begin
              in_comment_d = 1'b0;
            end
          end else if (is_ws) begin
            do_finish = in_token_q;
          end else if (!in_token_q && byte_i == CH_HASH) begin
            in_comment_d = 1'b1;
          end else begin
            if (!in_token_q) begin
              in_token_d = 1'b1;
              accum_d    = '0;
              digit_d    = 1'b0;
              stop_d     = 1'b0;
              neg_d      = (byte_i == CH_MINUS);
              skip_sign  = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);
              magic_d    = (byte_i == CH_P) ? MM_P : MM_BAD;
            end else begin
              magic_d = (magic_q == MM_P && byte_i == CH_5) ? MM_P5 : MM_BAD;
            end
            if (!skip_sign && !stop_d) begin
              if (is_digit) begin
                accum_d = acc_sat ? AccSat : acc_x10[24:0];
                digit_d = 1'b1;
              end else begin
                stop_d = 1'b1;
              end
            end
            // a token still open at end of file is closed here
            do_finish = eof_i;
          end

          if (do_finish) begin
            in_token_d = 1'b0;
            tok_val    = neg_d ? '0 : accum_d;
            if (tok_cnt_q == 2'd0) begin
              if (magic_d != MM_P5) begin
                fail_en = 1'b1;
                fail_st = ST_NOT_P5;
                phase_d = PH_DONE;
              end else begin
                tok_cnt_d = 2'd1;
              end
            end else if (!digit_d) begin
              fail_en = 1'b1;
              fail_st = ST_MALFORMED;
              phase_d = PH_DONE;
            end else begin
              case (tok_cnt_q)
                2'd1: begin
                  width_d   = tok_val;
                  tok_cnt_d = 2'd2;
                end
                2'd2: begin
                  height_d  = tok_val;
                  tok_cnt_d = 2'd3;
                end
                default: begin
                  if (width_q == '0 || height_q == '0 || cells > MaxCells) begin
                    fail_en = 1'b1;
                    fail_st = ST_BAD_SIZE;
                    phase_d = PH_DONE;
                  end else if (tok_val == '0 || tok_val > MaxvalLimit) begin
                    fail_en = 1'b1;
                    fail_st = ST_BAD_MAXVAL;
                    phase_d = PH_DONE;
                  end else begin
                    main_en             = 1'b1;
                    main_r.kind         = KIND_HEADER;
                    main_r.image_width  = width_q;
                    main_r.image_height = height_q;
                    cells_left_d        = cells[24:0];
                    row_base_d          = cells[23:0] - width_q[23:0];
                    col_d               = '0;
                    phase_d             = PH_PIX;
                  end
                end
              endcase
            end
          end

          if (eof_i) begin
            if (phase_d == PH_HDR) begin
              fail_en = 1'b1;
              fail_st = ST_BAD_SIZE;
              phase_d = PH_DONE;
            end else if (phase_d == PH_PIX) begin
              fail_en = 1'b1;
              fail_st = ST_TRUNCATED;
              phase_d = PH_DONE;
            end
          end
        end

        PH_PIX: begin
          main_en           = 1'b1;
          main_r.kind       = KIND_CELL;
          main_r.cell_index = row_base_q + col_q;
          main_r.cell_value = cls;
          cells_left_d      = cells_left_q - 25'd1;
          col_inc           = col_q + 24'd1;
          // end of a pixel row moves one grid row down
          if ({1'b0, col_inc} >= width_q) begin
            col_d      = '0;
            row_base_d = row_base_q - width_q[23:0];
          end else begin
            col_d = col_inc;
          end
          if (cells_left_d == '0) begin
            fail_en = 1'b1;
            fail_st = ST_OK;
            phase_d = PH_DONE;
          end else if (eof_i) begin
            fail_en = 1'b1;
            fail_st = ST_TRUNCATED;
            phase_d = PH_DONE;
          end
        end

        default: ;
      endcase

      // next byte starts a new file
      if (eof_i) begin
        phase_d      = PH_HDR;
        magic_d      = MM_NONE;
        tok_cnt_d    = '0;
        in_comment_d = 1'b0;
        in_token_d   = 1'b0;
        accum_d      = '0;
        neg_d        = 1'b0;
        digit_d      = 1'b0;
        stop_d       = 1'b0;
        width_d      = '0;
        height_d     = '0;
        col_d        = '0;
        row_base_d   = '0;
        cells_left_d = '0;
      end
    end
  end

  assign push_n_o       = {1'b0, main_en} + {1'b0, fail_en};
  assign push_data_o[0] = main_en ? main_r : status_result(fail_st);
  assign push_data_o[1] = status_result(fail_st);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR;
      magic_q      <= MM_NONE;
      tok_cnt_q    <= '0;
      in_comment_q <= 1'b0;
      in_token_q   <= 1'b0;
      accum_q      <= '0;
      neg_q        <= 1'b0;
      digit_q      <= 1'b0;
      stop_q       <= 1'b0;
      width_q      <= '0;
      height_q     <= '0;
      col_q        <= '0;
      row_base_q   <= '0;
      cells_left_q <= '0;
    end else begin
      phase_q      <= phase_d;
      magic_q      <= magic_d;
      tok_cnt_q    <= tok_cnt_d;
      in_comment_q <= in_comment_d;
      in_token_q   <= in_token_d;
      accum_q      <= accum_d;
      neg_q        <= neg_d;
      digit_q      <= digit_d;
      stop_q       <= stop_d;
      width_q      <= width_d;
      height_q     <= height_d;
      col_q        <= col_d;
      row_base_q   <= row_base_d;
      cells_left_q <= cells_left_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pgm_occ_result_fifo.sv
// ----------------------------------------------------------------------------
// pgm_occ_result_fifo
// Small result queue: takes up to two results per cycle, hands out one per pop.
// ----------------------------------------------------------------------------
`default_nettype none

module pgm_occ_result_fifo
  import pgm_occ_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [1:0]     push_n_i,
  input  wire result_t [1:0]  push_data_i,
  input  wire logic           pop_i,
  output logic                room_o,
  output logic                valid_o,
  output result_t             data_o
);

  result_t             mem_q [FifoDepth];
  logic [FifoAw-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [FifoAw:0]     cnt_q, cnt_d;

  // room for the worst case of two results from one byte
  assign room_o  = cnt_q <= (FifoAw + 1)'(FifoDepth - 2);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];

  assign wp_d  = wp_q + FifoAw'(push_n_i);
  assign rp_d  = rp_q + FifoAw'(pop_i);
  assign cnt_d = cnt_q + (FifoAw + 1)'(push_n_i) - (FifoAw + 1)'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wp_q] <= push_data_i[0];
    end
    if (push_n_i == 2'd2) begin
      mem_q[wp_q + FifoAw'(1)] <= push_data_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pgm_to_occupancy_grid_top.sv
// ----------------------------------------------------------------------------
// pgm_to_occupancy_grid_top
// Decodes a binary PGM (P5) byte stream into occupancy grid cell results.
// ----------------------------------------------------------------------------
//   Input channel (in_valid_i / in_stall_o) carries one file byte per transfer
//   with end_of_file_i set on the last byte of a file. Output channel
//   (out_valid_o / out_stall_i) carries results: one header result once the
//   header checks pass, one cell per pixel byte, and a status result with
//   last_result_o set that closes every file. Bytes after the status result
//   are dropped up to the end-of-file byte.
//   A byte is decoded while it sits in the input register; its results go
//   into the result queue, whose head drives the output channel.
//   One byte per cycle is sustained while the queue has room; a byte that
//   yields a cell plus a status puts two results into the four-entry result
//   queue. The input stalls only while that queue has fewer than two free
//   entries. Holding out_stall_i keeps the current result stable and backs
//   up into in_stall_o. Reset clears the decoder to the start of a file and
//   loads the default thresholds. The user must make configuration writes
//   only while idle (the block does not enforce it); they are kept across files.
// ----------------------------------------------------------------------------
`default_nettype none

module pgm_to_occupancy_grid_top
  import pgm_occ_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_addr_i,
  input  wire logic [16:0]       cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              end_of_file_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             kind_o,
  output logic [23:0]            cell_index_o,
  output logic signed [7:0]      cell_value_o,
  output logic [24:0]            image_width_o,
  output logic [24:0]            image_height_o,
  output logic [2:0]             status_o,
  output logic                   last_result_o
);

  cfg_t          cfg_q;
  logic          in_vld_q;
  logic [7:0]    byte_q;
  logic          eof_q;
  logic          fifo_room, fire, pop, fifo_valid;
  logic [1:0]    push_n;
  result_t [1:0] push_data;
  result_t       head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.negate   <= 1'b0;
      cfg_q.occ_thr  <= OccThrReset;
      cfg_q.free_thr <= FreeThrReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_NEGATE:   cfg_q.negate   <= cfg_wdata_i[0];
        CFG_OCC_THR:  cfg_q.occ_thr  <= cfg_wdata_i;
        CFG_FREE_THR: cfg_q.free_thr <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  assign fire       = in_vld_q & fifo_room;
  assign in_stall_o = in_vld_q & ~fifo_room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      eof_q  <= end_of_file_i;
    end
  end

  pgm_occ_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fire_i      (fire),
    .byte_i      (byte_q),
    .eof_i       (eof_q),
    .push_n_o    (push_n),
    .push_data_o (push_data)
  );

  assign pop = fifo_valid & ~out_stall_i;

  pgm_occ_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (push_data),
    .pop_i       (pop),
    .room_o      (fifo_room),
    .valid_o     (fifo_valid),
    .data_o      (head)
  );

  assign out_valid_o    = fifo_valid;
  assign kind_o         = head.kind;
  assign cell_index_o   = head.cell_index;
  assign cell_value_o   = head.cell_value;
  assign image_width_o  = head.image_width;
  assign image_height_o = head.image_height;
  assign status_o       = head.status;
  assign last_result_o  = head.last_result;

endmodule

`default_nettype wire

FILE: hw/rtl/pgm_occ_checker.sv
// ----------------------------------------------------------------------------
// pgm_occ_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module pgm_occ_checker
  import pgm_occ_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              out_valid_o,
  input  wire logic              out_stall_i,
  input  wire logic [1:0]        kind_o,
  input  wire logic [23:0]       cell_index_o,
  input  wire logic signed [7:0] cell_value_o,
  input  wire logic [24:0]       image_width_o,
  input  wire logic [24:0]       image_height_o,
  input  wire logic [2:0]        status_o,
  input  wire logic              last_result_o
);

  // the closing flag marks status results and nothing else
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_result_o == (kind_o == KIND_STATUS)))
    else $error("last_result does not match a status result");

  // a header is only sent after a nonzero size passed the checks
  a_header_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HEADER |->
      image_width_o != '0 && image_height_o != '0 && status_o == ST_OK)
    else $error("header result with empty size");

  // cells carry one of the three classes
  a_cell_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_CELL |->
      (cell_value_o == CELL_OCCUPIED || cell_value_o == CELL_FREE ||
       cell_value_o == CELL_UNKNOWN))
    else $error("cell result with unknown class");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(cell_index_o) && $stable(cell_value_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind pgm_to_occupancy_grid_top pgm_occ_checker u_pgm_occ_checker (.*);

`default_nettype wire

FILE: tb/tb_pgm_to_occupancy_grid_top.sv
// ----------------------------------------------------------------------------
// tb_pgm_to_occupancy_grid_top
// Streams PGM (P5) files through the decoder and checks every result against
// a cycle-free decoder written here. Directed files cover header corner cases
// (magic, sizes, maxval, comments, signs, saturation, end of file in the
// header) and cell classes. They are followed by random files under several
// threshold settings. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_pgm_to_occupancy_grid_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pgm_occ_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 12;
  localparam logic [7:0]  CH_VT       = 8'h0B;
  localparam logic [7:0]  CH_FF       = 8'h0C;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [1:0]        cfg_addr_i    = '0;
  logic [16:0]       cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i   = '0;
  logic              end_of_file_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [1:0]        kind_o;
  logic [23:0]       cell_index_o;
  logic signed [7:0] cell_value_o;
  logic [24:0]       image_width_o;
  logic [24:0]       image_height_o;
  logic [2:0]        status_o;
  logic              last_result_o;

  pgm_to_occupancy_grid_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .cell_index_o   (cell_index_o),
    .cell_value_o   (cell_value_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .status_o       (status_o),
    .last_result_o  (last_result_o)
  );

  always #6 clk_i = ~clk_i;

  file_byte_t file_bytes_q[$];
  logic [7:0] file_buf[$];
  result_t    grid_due_q[$];
  int         err_cnt   = 0;
  int         cycle_cnt = 0;

  // decoder copy: configuration and per-file parse state
  cfg_t        m_cfg;
  phase_e      m_phase;
  magic_e      m_magic;
  logic [1:0]  m_tok;
  logic        m_cmt, m_in_tok, m_neg, m_digit, m_stop;
  logic [24:0] m_acc, m_w, m_h, m_mv, m_left;
  logic [23:0] m_col, m_row;

  task automatic restart_file();
    m_phase  = PH_HDR;
    m_magic  = MM_NONE;
    m_tok    = '0;
    m_cmt    = 1'b0;
    m_in_tok = 1'b0;
    m_neg    = 1'b0;
    m_digit  = 1'b0;
    m_stop   = 1'b0;
    m_acc    = '0;
    m_w      = '0;
    m_h      = '0;
    m_mv     = '0;
    m_left   = '0;
    m_col    = '0;
    m_row    = '0;
  endtask

  task automatic push_result(input logic [1:0] k, input logic [23:0] idx,
                             input logic [7:0] val, input logic [24:0] w,
                             input logic [24:0] h, input logic [2:0] st,
                             input logic last);
    result_t r;
    r              = '0;
    r.kind         = k;
    r.cell_index   = idx;
    r.cell_value   = val;
    r.image_width  = w;
    r.image_height = h;
    r.status       = st;
    r.last_result  = last;
    grid_due_q.insert(grid_due_q.size(), r);
  endtask

  task automatic end_file(input logic [2:0] st);
    push_result(KIND_STATUS, '0, '0, '0, '0, st, 1'b1);
    m_phase = PH_DONE;
  endtask

  task automatic close_token();
    logic [24:0] v;
    logic [63:0] cells;
    logic [63:0] prod;
    m_in_tok = 1'b0;
    if (m_tok == 2'd0) begin
      if (m_magic != MM_P5) end_file(ST_NOT_P5);
      else m_tok = 2'd1;
    end else if (!m_digit) begin
      end_file(ST_MALFORMED);
    end else begin
      v = m_neg ? '0 : m_acc;
      case (m_tok)
        2'd1: begin
          m_w   = v;
          m_tok = 2'd2;
        end
        2'd2: begin
          m_h   = v;
          m_tok = 2'd3;
        end
        default: begin
          m_mv  = v;
          cells = 64'(m_w) * 64'(m_h);
          if (m_w == '0 || m_h == '0 || cells > 64'(MaxCells)) begin
            end_file(ST_BAD_SIZE);
          end else if (m_mv == '0 || m_mv > MaxvalLimit) begin
            end_file(ST_BAD_MAXVAL);
          end else begin
            push_result(KIND_HEADER, '0, '0, m_w, m_h, ST_OK, 1'b0);
            m_left  = cells[24:0];
            prod    = 64'(m_h - 25'd1) * 64'(m_w);
            m_row   = prod[23:0];
            m_col   = '0;
            m_phase = PH_PIX;
          end
        end
      endcase
    end
  endtask

  // one accepted byte: update the decoder copy and queue what it yields
  task automatic decode_byte(input logic [7:0] b, input logic eof);
    logic        skip;
    logic [31:0] nv;
    logic [63:0] num;
    logic [63:0] scaled;
    logic [7:0]  cls;
    case (m_phase)
      PH_HDR: begin
        if (m_cmt) begin
          if (b == CH_LF) m_cmt = 1'b0;
        end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
          if (m_in_tok) close_token();
        end else if (!m_in_tok && b == CH_HASH) begin
          m_cmt = 1'b1;
        end else begin
          skip = 1'b0;
          if (!m_in_tok) begin
            m_in_tok = 1'b1;
            m_acc    = '0;
            m_neg    = 1'b0;
            m_digit  = 1'b0;
            m_stop   = 1'b0;
            if (b == CH_P) m_magic = MM_P;
            else m_magic = MM_BAD;
            if (b == CH_PLUS || b == CH_MINUS) begin
              m_neg = (b == CH_MINUS);
              skip  = 1'b1;
            end
          end else if (m_magic == MM_P && b == CH_5) begin
            m_magic = MM_P5;
          end else begin
            m_magic = MM_BAD;
          end
          if (!skip && !m_stop) begin
            if (b >= CH_0 && b <= CH_9) begin
              nv = 32'(m_acc) * 32'd10 + 32'(b - CH_0);
              // saturate so oversized values fail the size or maxval check
              if (m_acc > AccSatDiv10 || nv > 32'(AccSat)) nv = 32'(AccSat);
              m_acc   = nv[24:0];
              m_digit = 1'b1;
            end else begin
              m_stop = 1'b1;
            end
          end
        end
        if (eof) begin
          if (m_phase == PH_HDR && m_in_tok) close_token();
          if (m_phase == PH_HDR) end_file(ST_BAD_SIZE);
          else if (m_phase == PH_PIX) end_file(ST_TRUNCATED);
        end
      end
      PH_PIX: begin
        num    = m_cfg.negate ? 64'(b) : 64'(8'd255 - b);
        scaled = num << 16;
        if (scaled > 64'(m_cfg.occ_thr) * 64'd255) cls = CELL_OCCUPIED;
        else if (scaled < 64'(m_cfg.free_thr) * 64'd255) cls = CELL_FREE;
        else cls = CELL_UNKNOWN;
        push_result(KIND_CELL, m_row + m_col, cls, '0, '0, ST_OK, 1'b0);
        m_left = m_left - 25'd1;
        m_col  = m_col + 24'd1;
        if (25'(m_col) >= m_w) begin
          m_col = '0;
          m_row = m_row - m_w[23:0];
        end
        if (m_left == '0) end_file(ST_OK);
        else if (eof) end_file(ST_TRUNCATED);
      end
      default: ;
    endcase
    if (eof) restart_file();
  endtask

  // idle by chance, 8 in 100, never in the calm stretch of each window
  function automatic bit take_break();
    return ((cycle_cnt % 3000) < 2000) && ($urandom_range(99) < 8);
  endfunction

  always @(posedge clk_i) begin : byte_driver
    logic go;
    if (in_valid_i && !in_stall_o) begin
      decode_byte(file_bytes_q[0].data, file_bytes_q[0].eof);
      void'(file_bytes_q.pop_front());
    end
    // a stalled byte stays on the bus unchanged
    go = rst_ni && file_bytes_q.size() != 0 &&
         ((in_valid_i && in_stall_o) || !take_break());
    in_valid_i <= go;
    if (go) begin
      data_byte_i   <= file_bytes_q[0].data;
      end_of_file_i <= file_bytes_q[0].eof;
    end
  end

  task automatic check_field(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (grid_due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d index %0d",
                 $time, kind_o, cell_index_o);
        err_cnt++;
      end else begin
        want = grid_due_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("cell_index", 32'(want.cell_index), 32'(cell_index_o));
        check_field("cell_value", 32'(want.cell_value), 32'(cell_value_o));
        check_field("image_width", 32'(want.image_width), 32'(image_width_o));
        check_field("image_height", 32'(want.image_height), 32'(image_height_o));
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("last_result", 32'(want.last_result), 32'(last_result_o));
      end
    end
    out_stall_i <= take_break();
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout, %0d bytes and %0d results outstanding", $time,
               file_bytes_q.size(), grid_due_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(input logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // hand the file to the driver, end_of_file on its last byte
  task automatic flush_file();
    file_byte_t fb;
    foreach (file_buf[i]) begin
      fb.data = file_buf[i];
      fb.eof  = (i == file_buf.size() - 1);
      file_bytes_q.insert(file_bytes_q.size(), fb);
    end
    file_buf.delete();
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic add_gap();
    logic [7:0] b;
    repeat ($urandom_range(2, 1)) add_byte(pick_space());
    if ($urandom_range(7) == 0) begin
      add_byte(CH_HASH);
      repeat ($urandom_range(6)) begin
        b = 8'($urandom_range(255));
        if (b == CH_LF) b = CH_SPACE;
        add_byte(b);
      end
      add_byte(CH_LF);
    end
  endtask

  function automatic string num_text(input longint v);
    string s;
    s = $sformatf("%0d", v);
    if (v >= 0) begin
      case ($urandom_range(9))
        0:       s = {"+", s};
        1:       s = {"00", s};
        default: ;
      endcase
    end
    return s;
  endfunction

  task automatic random_file(output int n_used);
    int     sel, flaw, cells, npix, cut;
    longint w, h, mv;
    string  magic, ws, hs, ms, junk;
    sel   = $urandom_range(99);
    flaw  = $urandom_range(8);
    magic = "P5";
    w     = longint'($urandom_range(8, 1));
    h     = longint'($urandom_range(6, 1));
    mv    = longint'($urandom_range(255, 1));
    cells = int'(w * h);
    if (sel >= 65 && sel < 73) begin
      // big grids, cut short by end of file
      mv = 255;
      case ($urandom_range(2))
        0: begin
          w = 16777216;
          h = 1;
        end
        1: begin
          w = 4096;
          h = 4096;
        end
        default: begin
          w = longint'($urandom_range(4000, 300));
          h = longint'($urandom_range(4000, 300));
        end
      endcase
    end else if (sel >= 73) begin
      case (flaw)
        0: w = 0;
        1: h = -longint'($urandom_range(50, 1));
        2: begin
          w = longint'($urandom_range(60000, 4097));
          h = longint'($urandom_range(60000, 4097));
        end
        3: w = longint'(1) << $urandom_range(40, 25);
        4: mv = 0;
        5: mv = longint'($urandom_range(70000, 256));
        default: ;
      endcase
    end
    ws = num_text(w);
    hs = num_text(h);
    ms = num_text(mv);
    if (sel >= 73 && flaw == 6) begin
      case ($urandom_range(4))
        0:       junk = "x7";
        1:       junk = "-";
        2:       junk = "+";
        3:       junk = "--3";
        default: junk = "q";
      endcase
      case ($urandom_range(2))
        0:       ws = junk;
        1:       hs = junk;
        default: ms = junk;
      endcase
    end
    if (sel >= 73 && flaw == 7) begin
      case ($urandom_range(5))
        0:       magic = "P6";
        1:       magic = "P";
        2:       magic = "P55";
        3:       magic = "p5";
        4:       magic = "P5x";
        default: magic = "+P5";
      endcase
    end
    if ($urandom_range(3) == 0) add_gap();
    add_text(magic);
    add_gap();
    add_text(ws);
    add_gap();
    add_text(hs);
    add_gap();
    add_text(ms);
    add_byte(pick_space());
    if (sel >= 90) begin
      // noise: header cut anywhere, or plain random bytes
      if ($urandom_range(1) == 0) begin
        cut = $urandom_range(file_buf.size(), 1);
        while (file_buf.size() > cut) file_buf.delete(file_buf.size() - 1);
      end else begin
        file_buf.delete();
        repeat ($urandom_range(12, 1)) add_byte(8'($urandom_range(255)));
      end
    end else begin
      if (sel < 65) npix = ($urandom_range(9) == 0) ? $urandom_range(cells - 1, 0) : cells;
      else npix = $urandom_range(6, 0);
      repeat (npix) add_byte(8'($urandom_range(255)));
    end
    n_used = file_buf.size();
    if (sel < 90 && $urandom_range(3) == 0) begin
      repeat ($urandom_range(4, 1)) add_byte(8'($urandom_range(255)));
    end
    flush_file();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_NEGATE:  m_cfg.negate   = val[0];
      CFG_OCC_THR: m_cfg.occ_thr  = val;
      default:     m_cfg.free_thr = val;
    endcase
  endtask

  task automatic set_config(input logic neg, input logic [16:0] occ,
                            input logic [16:0] fre);
    write_reg(CFG_NEGATE, {16'd0, neg});
    write_reg(CFG_OCC_THR, occ);
    write_reg(CFG_FREE_THR, fre);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for every byte and result, then let the pipeline empty
  task automatic settle();
    while (file_bytes_q.size() != 0 || grid_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int used;
    int n;
    m_cfg.negate   = 1'b0;
    m_cfg.occ_thr  = OccThrReset;
    m_cfg.free_thr = FreeThrReset;
    restart_file();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed files under the reset thresholds
    add_text("P5 3 2 255\n");
    add_byte(8'd0);
    add_byte(8'd255);
    add_byte(8'd1);
    add_byte(8'd254);
    add_byte(8'd77);
    add_byte(8'd200);
    flush_file();
    add_text("#hdr\nP5\t2\r1");
    add_byte(CH_VT);
    add_text("1");
    add_byte(CH_FF);
    add_byte(8'd128);
    add_byte(8'd127);
    add_text("tail");
    flush_file();
    add_text("P6 1 1 255 x");
    flush_file();
    add_text("P 2 2 9 ");
    flush_file();
    add_text("P55 1 1 9 ");
    flush_file();
    add_text("P5 0 4 255 ");
    flush_file();
    add_text("P5 4 -3 255 ");
    flush_file();
    add_text("P5 99999999999 1 255 ");
    flush_file();
    add_text("P5 16777217 1 255 ");
    flush_file();
    add_text("P5 4096 4096 255 abc");
    flush_file();
    add_text("P5 16777216 1 255 ");
    add_byte(8'd255);
    flush_file();
    add_text("P5 2 2 0 ");
    flush_file();
    add_text("P5 2 2 256 ");
    flush_file();
    add_text("P5 abc 2 255 ");
    flush_file();
    add_text("P5 +3x 1 1 ");
    add_byte(8'd10);
    add_byte(8'd245);
    add_byte(8'd100);
    flush_file();
    add_text("P5 - 1 1 ");
    flush_file();
    add_text("P5 4 4");
    flush_file();
    add_text("P5 1 1 255");
    flush_file();
    add_text("P5 1 1 255\n");
    flush_file();
    add_text("P5 2#3 1 255 #\n");
    flush_file();
    add_text("P5 #note 5\n2 1 255 ");
    add_byte(8'd60);
    add_byte(8'd190);
    flush_file();
    add_text("P5 2 #abc");
    flush_file();
    add_text("P5 0001 +1 255 ");
    add_byte(8'd33);
    flush_file();
    settle();

    // random files, one threshold setting per round
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       set_config(1'b1, 17'd65536, 17'd0);
        1:       set_config(1'b0, 17'd0, 17'd65536);
        2:       set_config(1'b1, 17'($urandom_range(65536)), 17'($urandom_range(65536)));
        3:       set_config(1'b0, 17'($urandom_range(65536)), 17'($urandom_range(65536)));
        default: set_config(1'b1, OccThrReset, FreeThrReset);
      endcase
      used = 0;
      while (used < 170) begin
        random_file(n);
        used += n;
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
